// ----- sv/number_to_ascii_digits_defines.svh -----
// ---------------------------------------------------------------------------
// number_to_ascii_digits assertion macros
// shared assertion wrappers for the binary to ascii converter
// ---------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_DIGITS_DEFINES_SVH
`define NUMBER_TO_ASCII_DIGITS_DEFINES_SVH

`ifndef ASSERT_OFF
`define N2A_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("n2a assertion failed");
`define N2A_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("n2a assertion failed");
`else
`define N2A_ASSERT(label, clk, rst, prop)
`define N2A_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- sv/n2a_pkg.sv -----
// ---------------------------------------------------------------------------
// n2a_pkg
// types and constants shared by the binary to ascii converter
// ---------------------------------------------------------------------------
package n2a_pkg;

  localparam int unsigned BIN_W      = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = NUM_DIGITS * 4;
  localparam int unsigned STEP_W     = $clog2(BIN_W);
  localparam int unsigned WIDTH_W    = 4;
  localparam int unsigned CHAR_W     = 7;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
  localparam logic [3:0]        TEN        = 4'hA;

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  typedef struct packed {
    logic             start;
    logic [BIN_W-1:0] value;
  } dabble_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dabble_stat_t;

endpackage

// ----- sv/number_to_ascii_digits.sv -----
// ---------------------------------------------------------------------------
// number_to_ascii_digits
// converts a 32-bit value to zero-padded ascii decimal or hex digits
// ---------------------------------------------------------------------------
// decimal: CONV runs the 32-step shift-add-3 loop, then COUNT sets the first digit
// hex: nibbles taken directly, COUNT sets the first digit with no conversion
// then one digit per cycle while m_tready is high, up to MAX_WIDTH digits
// next input beat taken once the last digit beat has gone out
// rst is synchronous, active high, and returns the block to idle
`include "number_to_ascii_digits_defines.svh"

module number_to_ascii_digits #(
  parameter int unsigned MAX_WIDTH = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], hex_mode[32], min_width[36:33], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // digit_char[6:0], zero fill
  output logic        m_tlast
);

  typedef enum logic [1:0] {IDLE, CONV, COUNT, EMIT} state_t;

  state_t                         state;
  n2a_pkg::digits_t               digits;
  n2a_pkg::digits_t               bcd;
  logic [n2a_pkg::WIDTH_W-1:0]    want;
  logic [n2a_pkg::WIDTH_W-1:0]    pos;
  logic [n2a_pkg::WIDTH_W-1:0]    count;
  logic [n2a_pkg::WIDTH_W-1:0]    total;
  logic [n2a_pkg::WIDTH_W-1:0]    in_width;
  n2a_pkg::dabble_ctrl_t          dctrl;
  n2a_pkg::dabble_stat_t          dstat;
  logic                           in_beat;
  logic                           out_beat;

  function automatic logic [n2a_pkg::CHAR_W-1:0] char_at(
    input logic [n2a_pkg::WIDTH_W-1:0] p,
    input logic [n2a_pkg::WIDTH_W-1:0] cnt,
    input n2a_pkg::digits_t            d
  );
    logic [3:0] nib;
    nib = 4'd0;
    for (int i = 0; i < n2a_pkg::NUM_DIGITS; i++) begin
      if (p == n2a_pkg::WIDTH_W'(i)) nib = d[i];
    end
    if (p >= cnt) begin
      return n2a_pkg::ASCII_ZERO;
    end else if (nib >= n2a_pkg::TEN) begin
      return n2a_pkg::ASCII_A + n2a_pkg::CHAR_W'(nib - n2a_pkg::TEN);
    end else begin
      return n2a_pkg::ASCII_ZERO + n2a_pkg::CHAR_W'(nib);
    end
  endfunction

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;
  assign s_tready = (state == IDLE);

  assign in_width = s_tdata[36:33];

  assign dctrl.start = in_beat && !s_tdata[32];
  assign dctrl.value = s_tdata[31:0];

  n2a_dabble u_dabble (
    .clk  (clk),
    .rst  (rst),
    .ctrl (dctrl),
    .stat (dstat),
    .bcd  (bcd)
  );

  // digit count: position of the highest nonzero digit, at least one
  always_comb begin
    count = n2a_pkg::WIDTH_W'(1);
    for (int i = 1; i < n2a_pkg::NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) count = n2a_pkg::WIDTH_W'(i + 1);
    end
    total = (want > count) ? want : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_beat) begin
            state <= s_tdata[32] ? COUNT : CONV;
          end
        end
        CONV: begin
          if (dstat.done) state <= COUNT;
        end
        COUNT: begin
          state    <= EMIT;
          m_tvalid <= 1'b1;
        end
        EMIT: begin
          if (out_beat && m_tlast) begin
            state    <= IDLE;
            m_tvalid <= 1'b0;
          end
        end
        default: begin
          state    <= IDLE;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      want   <= (in_width > n2a_pkg::WIDTH_W'(MAX_WIDTH)) ?
                n2a_pkg::WIDTH_W'(MAX_WIDTH) : in_width;
      digits <= {8'd0, s_tdata[31:0]};
    end else if (state == CONV && dstat.done) begin
      digits <= bcd;
    end
    if (state == COUNT) begin
      pos     <= total - 1'b1;
      m_tdata <= {1'b0, char_at(total - 1'b1, count, digits)};
      m_tlast <= (total == n2a_pkg::WIDTH_W'(1));
    end else if (state == EMIT && out_beat && !m_tlast) begin
      pos     <= pos - 1'b1;
      m_tdata <= {1'b0, char_at(pos - 1'b1, count, digits)};
      m_tlast <= (pos == n2a_pkg::WIDTH_W'(1));
    end
  end

  `N2A_ASSERT(a_in_blocks, clk, rst, in_beat |=> !s_tready)
  `N2A_ASSERT(a_last_frees, clk, rst, out_beat && m_tlast |=> s_tready)
  `N2A_ASSERT(a_no_overlap, clk, rst, m_tvalid |-> !s_tready)
  `N2A_ASSERT(a_char_range, clk, rst,
    m_tvalid |-> (m_tdata >= 8'h30 && m_tdata <= 8'h46))

endmodule

// ----- sv/n2a_dabble.sv -----
// ---------------------------------------------------------------------------
// n2a_dabble
// iterative shift-and-add-3 binary to bcd converter, one bit per cycle
// ---------------------------------------------------------------------------
`include "number_to_ascii_digits_defines.svh"

module n2a_dabble (
  input  logic                  clk,
  input  logic                  rst,
  input  n2a_pkg::dabble_ctrl_t ctrl,
  output n2a_pkg::dabble_stat_t stat,
  output n2a_pkg::digits_t      bcd
);

  logic [n2a_pkg::BIN_W-1:0]  bin;
  logic [n2a_pkg::STEP_W-1:0] step;
  logic                       busy;
  logic                       done;
  n2a_pkg::digits_t           adj;

  // add 3 to every nibble at 5 or above before the shift
  always_comb begin
    for (int i = 0; i < n2a_pkg::NUM_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == n2a_pkg::STEP_W'(n2a_pkg::BIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start && !busy) begin
      bin <= ctrl.value;
      bcd <= '0;
    end else if (busy) begin
      {bcd, bin} <= {adj[n2a_pkg::NUM_DIGITS-1:0], bin} << 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  `N2A_ASSERT(a_start_busy, clk, rst, ctrl.start && !busy |=> busy)
  `N2A_ASSERT(a_done_idle, clk, rst, done |-> !busy)
  `N2A_ASSERT(a_done_pulse, clk, rst, done |=> !done)

endmodule

// ----- bench/number_to_ascii_digits_checker.sv -----
// ---------------------------------------------------------------------------
// number_to_ascii_digits_checker
// watches both stream channels of the converter, works out the digit string
// for every accepted number and compares each digit beat against it
// ---------------------------------------------------------------------------
module number_to_ascii_digits_checker #(
  parameter int unsigned MAX_WIDTH = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], hex_mode[32], min_width[36:33], zero fill
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // digit_char[6:0], zero fill
  input  logic        m_tlast,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [n2a_pkg::CHAR_W-1:0] glyph;
    logic                       last;
  } digit_beat_t;

  digit_beat_t pending_digits[$];
  int          fail_count = 0;
  int          pending_count = 0;

  assign errors      = fail_count;
  assign outstanding = pending_count;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  // digits are gathered least significant first, then emitted in reverse
  // behind any zero padding
  task automatic queue_digits(input logic [n2a_pkg::BIN_W-1:0] number, input logic hex,
                              input logic [n2a_pkg::WIDTH_W-1:0] min_width);
    logic [3:0]                rev [n2a_pkg::NUM_DIGITS];
    logic [n2a_pkg::BIN_W-1:0] rest;
    logic [3:0]                nib;
    int                        count;
    int                        want;
    int                        pad;
    digit_beat_t               beat;
    rest  = number;
    count = 0;
    want  = int'(min_width);
    if (want > int'(MAX_WIDTH)) want = int'(MAX_WIDTH);
    do begin
      if (hex) begin
        rev[count] = rest[3:0];
        rest = rest >> 4;
      end else begin
        rev[count] = 4'(rest % 10);
        rest = rest / 10;
      end
      count++;
    end while (rest != 0 && count < int'(n2a_pkg::NUM_DIGITS));
    pad = (want > count) ? want - count : 0;
    for (int k = 0; k < pad + count; k++) begin
      if (k < pad) begin
        beat.glyph = n2a_pkg::ASCII_ZERO;
      end else begin
        nib = rev[count - 1 - (k - pad)];
        if (nib >= n2a_pkg::TEN) begin
          beat.glyph = n2a_pkg::ASCII_A + n2a_pkg::CHAR_W'(nib - n2a_pkg::TEN);
        end else begin
          beat.glyph = n2a_pkg::ASCII_ZERO + n2a_pkg::CHAR_W'(nib);
        end
      end
      beat.last = (k == pad + count - 1);
      pending_digits.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    digit_beat_t want_beat;
    if (rst) begin
      pending_digits.delete();
    end else begin
      // output side first so a digit can never match the number taken this edge
      if (m_tvalid && m_tready) begin
        if (pending_digits.size() == 0) begin
          report_mismatch($sformatf("digit beat 0x%02h with nothing outstanding",
                                    m_tdata[n2a_pkg::CHAR_W-1:0]));
        end else begin
          want_beat = pending_digits.pop_front();
          if (m_tdata[n2a_pkg::CHAR_W-1:0] !== want_beat.glyph)
            report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
                                      m_tdata[n2a_pkg::CHAR_W-1:0], want_beat.glyph));
          if (m_tlast !== want_beat.last)
            report_mismatch($sformatf("last %b, expected %b", m_tlast, want_beat.last));
        end
      end
      if (s_tvalid && s_tready)
        queue_digits(s_tdata[31:0], s_tdata[32], s_tdata[36:33]);
    end
    pending_count = pending_digits.size();
  end

endmodule

// ----- bench/number_to_ascii_digits_test.sv -----
// ---------------------------------------------------------------------------
// number_to_ascii_digits_test
// drives numbers into the converter with random gaps and back-pressure,
// directed corner values first, then random values in both radixes
// ---------------------------------------------------------------------------
module number_to_ascii_digits_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 48;
  localparam int N_RANDOM    = 207;
  localparam int CALM_FROM   = 170;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // value[31:0], hex_mode[32], min_width[36:33], zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // digit_char[6:0], zero fill
  logic        m_tlast;
  logic        calm_tail;
  int          errors;
  int          outstanding;
  int          stuck_cycles = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  number_to_ascii_digits u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  number_to_ascii_digits_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // returns right after the beat is taken at a rising edge
  task automatic send_number(input logic [31:0] number, input logic hex,
                             input logic [3:0] min_width);
    int gap;
    gap = (!calm_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, min_width, hex, number};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] pick_number();
    logic [31:0] power;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 99);
      2: return $urandom >> $urandom_range(0, 31);
      3: begin
        power = 1;
        repeat ($urandom_range(0, 9)) power = power * 10;
        return power + $urandom_range(0, 2) - 1;
      end
      4: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom >> (4 * $urandom_range(0, 7));
    endcase
  endfunction

  // receiver back-pressure, stall density redrawn at the start of each phase
  initial begin
    int stall_left;
    int stall_odds;
    int phase_cycles;
    m_tready     = 1'b0;
    stall_left   = 0;
    stall_odds   = 0;
    phase_cycles = 0;
    forever begin
      @(negedge clk);
      if (phase_cycles == 0) begin
        stall_odds   = $urandom_range(0, 2);
        phase_cycles = 64;
      end
      phase_cycles--;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!calm_tail && stall_odds != 0 && $urandom_range(0, 8 / stall_odds) == 0) begin
        m_tready   <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL number_to_ascii_digits");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    calm_tail = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero in both radixes, with and without padding
    send_number(32'h0, 1'b0, 4'd0);
    send_number(32'h0, 1'b1, 4'd0);
    send_number(32'h0, 1'b0, 4'd15);
    // all ones: longest natural strings, then padded to the widest
    send_number(32'hFFFF_FFFF, 1'b0, 4'd0);
    send_number(32'hFFFF_FFFF, 1'b1, 4'd0);
    send_number(32'hFFFF_FFFF, 1'b0, 4'd15);
    send_number(32'hFFFF_FFFF, 1'b1, 4'd15);
    // width equal to and one above the digit count, then widths at or below it
    send_number(32'hFFFF_FFFF, 1'b0, 4'd10);
    send_number(32'hFFFF_FFFF, 1'b0, 4'd11);
    send_number(32'd12345, 1'b0, 4'd3);
    send_number(32'hABCD_EF01, 1'b1, 4'd8);
    send_number(32'h8000_0000, 1'b1, 4'd1);
    // digit rollover points
    send_number(32'd9, 1'b0, 4'd0);
    send_number(32'd10, 1'b0, 4'd0);
    send_number(32'h9, 1'b1, 4'd0);
    send_number(32'hA, 1'b1, 4'd0);
    send_number(32'hF, 1'b1, 4'd2);
    send_number(32'h10, 1'b1, 4'd0);
    send_number(32'd999_999_999, 1'b0, 4'd0);
    send_number(32'd1_000_000_000, 1'b0, 4'd12);
    // alternating bit patterns, then a small hex value padded to the widest
    send_number(32'h5555_5555, 1'b1, 4'd9);
    send_number(32'hAAAA_AAAA, 1'b0, 4'd7);
    send_number(32'h7, 1'b1, 4'd15);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == CALM_FROM) calm_tail = 1'b1;
      send_number(pick_number(), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(0, 15)));
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("PASS number_to_ascii_digits");
    end else begin
      $display("FAIL number_to_ascii_digits");
    end
    $finish;
  end

endmodule
